### src/price_gap_zone_tracker_macros.svh
// Assertion helpers used by the RTL.
`ifndef PRICE_GAP_ZONE_TRACKER_MACROS_SVH
`define PRICE_GAP_ZONE_TRACKER_MACROS_SVH

// Implication checked on every edge outside reset.
`define PGZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define PGZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pgzt_pkg.sv
package pgzt_pkg;

	localparam int PRICE_W = 32;
	localparam int CNT_W   = 7;

	localparam logic [1:0] PH_ACTIVE    = 2'd0;
	localparam logic [1:0] PH_MITIGATED = 2'd1;
	localparam logic [1:0] PH_INVERTED  = 2'd2;
	localparam logic [1:0] PH_DEAD      = 2'd3;

	localparam logic [1:0] MIT_EDGE = 2'd0;
	localparam logic [1:0] MIT_MID  = 2'd1;
	localparam logic [1:0] MIT_FULL = 2'd2;

	localparam logic [2:0] REG_MIN_GAP   = 3'd0;
	localparam logic [2:0] REG_MIN_BODY  = 3'd1;
	localparam logic [2:0] REG_MIT_RULE  = 3'd2;
	localparam logic [2:0] REG_KEEP_INV  = 3'd3;
	localparam logic [2:0] REG_WICK      = 3'd4;
	localparam logic [2:0] REG_LIMIT     = 3'd5;

	localparam int CFG_W = 14;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DETECT,
		ST_TRIM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [PRICE_W-1:0] open_ticks;
		logic [PRICE_W-1:0] high_ticks;
		logic [PRICE_W-1:0] low_ticks;
		logic [PRICE_W-1:0] close_ticks;
	} bar_t;

	typedef struct packed {
		logic               new_zone;
		logic               new_bullish;
		logic [PRICE_W-1:0] new_top;
		logic [PRICE_W-1:0] new_bottom;
		logic [CNT_W-1:0]   mitigated_count;
		logic [CNT_W-1:0]   inverted_count;
		logic [CNT_W-1:0]   died_count;
		logic [CNT_W-1:0]   wick_full_count;
		logic [CNT_W-1:0]   wick_half_count;
		logic [CNT_W-1:0]   zones_held;
		logic               zone_evicted;
	} result_t;

	typedef struct packed {
		logic [PRICE_W-1:0] top;
		logic [PRICE_W-1:0] bottom;
		logic               bull;
		logic [1:0]         phase;
		logic               wick_full;
		logic               wick_half;
	} zone_t;

	localparam int ZONE_W = 2*PRICE_W + 5;

endpackage

### src/pgzt_ram.sv
module pgzt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/price_gap_zone_tracker.sv
// Three-bar price gap zone tracker. Each accepted bar word walks every stored zone
// once through a single-port-read zone RAM (one read issued per cycle, the update
// written back in the cycle after), then runs gap detection, append and trimming
// to the limit. Each bar passes through the walk, detection, the trim check (which
// drops the oldest zones while the count exceeds the limit) and the result post
// before the tracker returns to idle and takes the next bar. A result word is held
// in an output register; the next bar is taken while it waits, and the following
// result holds in the last step until the register has been handed over.
// Zones read only inside the ring count, so the RAM needs no clearing.
`include "price_gap_zone_tracker_macros.svh"

module price_gap_zone_tracker #(
	parameter int MAX_ZONES = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  pgzt_pkg::bar_t           in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output pgzt_pkg::result_t        out_data,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [pgzt_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int NW = $clog2(MAX_ZONES + 1);
	localparam int PW = pgzt_pkg::PRICE_W;
	localparam int CW = pgzt_pkg::CNT_W;

	// configuration
	logic [13:0] min_gap_q;
	logic [6:0]  min_body_q;
	logic [1:0]  mit_rule_q;
	logic        keep_inv_q;
	logic        wick_q;
	logic [6:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q  <= 14'd1;
			min_body_q <= 7'd0;
			mit_rule_q <= 2'd0;
			keep_inv_q <= 1'b1;
			wick_q     <= 1'b0;
			limit_q    <= 7'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				pgzt_pkg::REG_MIN_GAP:  min_gap_q  <= cfg_data[13:0];
				pgzt_pkg::REG_MIN_BODY: min_body_q <= cfg_data[6:0];
				pgzt_pkg::REG_MIT_RULE: mit_rule_q <= cfg_data[1:0];
				pgzt_pkg::REG_KEEP_INV: keep_inv_q <= cfg_data[0];
				pgzt_pkg::REG_WICK:     wick_q     <= cfg_data[0];
				pgzt_pkg::REG_LIMIT:    limit_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	pgzt_pkg::state_t state_q, state_d;

	pgzt_pkg::bar_t  bar_q;
	logic [PW-1:0]   hh0_q, hh1_q, lh0_q, lh1_q, mo_q, mc_q;
	logic [1:0]      seen_q;
	logic [AW-1:0]   head_q;
	logic [NW-1:0]   count_q;
	logic [NW-1:0]   walk_q;     // zones issued
	logic            rd_vld_s1;  // read data valid this cycle
	logic [AW-1:0]   rd_addr_s1;
	logic [CW-1:0]   n_mit_q, n_inv_q, n_died_q, n_full_q, n_half_q;
	logic            evict_q;
	logic            acc_q, bull_q;
	logic [PW-1:0]   top_q, bot_q;
	logic [1:0]      det_step_q;
	logic [PW+6:0]   prod_a_q, prod_b_q;
	logic            gap_ok_q;
	pgzt_pkg::result_t res_q;
	logic            out_vld_q;

	// RAM
	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	pgzt_pkg::zone_t     ram_wdata, ram_rdata;
	logic [pgzt_pkg::ZONE_W-1:0] ram_rbits;

	pgzt_ram #(.WIDTH(pgzt_pkg::ZONE_W), .DEPTH(MAX_ZONES)) u_zone_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rbits)
	);
	assign ram_rdata = pgzt_pkg::zone_t'(ram_rbits);

	function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
		logic [AW:0] m;
		m = v;
		if ({1'b0, v} >= (AW+2)'(MAX_ZONES)) begin
			m = v - (AW+1)'(MAX_ZONES);
		end
		return m[AW-1:0];
	endfunction

	// zone update of the word just read
	logic [PW-1:0] b_lo, b_hi, op, hi, lo, cl;
	logic [PW:0]   mid2, lo2, hi2;
	pgzt_pkg::zone_t z, zn;
	logic u_mit, u_inv, u_died, u_full, u_half;

	always_comb begin
		logic held, swept, half, mit;
		op = bar_q.open_ticks; hi = bar_q.high_ticks;
		lo = bar_q.low_ticks; cl = bar_q.close_ticks;
		b_lo = (op < cl) ? op : cl;
		b_hi = (op > cl) ? op : cl;
		z = ram_rdata;
		zn = z;
		mid2 = {1'b0, z.top} + {1'b0, z.bottom};
		lo2 = {lo, 1'b0};
		hi2 = {hi, 1'b0};
		u_mit = 1'b0; u_inv = 1'b0; u_died = 1'b0; u_full = 1'b0; u_half = 1'b0;
		held = 1'b0; swept = 1'b0; half = 1'b0; mit = 1'b0;
		if (z.phase == pgzt_pkg::PH_ACTIVE || z.phase == pgzt_pkg::PH_MITIGATED) begin
			if (wick_q) begin
				held  = z.bull ? (b_lo >= z.top) : (b_hi <= z.bottom);
				swept = z.bull ? (lo <= z.bottom) : (hi >= z.top);
				half  = z.bull ? (lo2 <= mid2) : (hi2 >= mid2);
				if (held) begin
					if (swept && !z.wick_full) begin
						zn.wick_full = 1'b1; zn.wick_half = 1'b1; u_full = 1'b1;
					end else if (half && !z.wick_half && !z.wick_full) begin
						zn.wick_half = 1'b1; u_half = 1'b1;
					end
				end
			end
			if (z.bull ? (cl < z.bottom) : (cl > z.top)) begin
				zn.phase = keep_inv_q ? pgzt_pkg::PH_INVERTED : pgzt_pkg::PH_DEAD;
				u_inv = 1'b1;
			end else if (z.phase == pgzt_pkg::PH_ACTIVE) begin
				case (mit_rule_q)
					pgzt_pkg::MIT_EDGE: mit = z.bull ? (lo <= z.top) : (hi >= z.bottom);
					pgzt_pkg::MIT_MID:  mit = z.bull ? (lo2 <= mid2) : (hi2 >= mid2);
					default:            mit = z.bull ? (lo <= z.bottom) : (hi >= z.top);
				endcase
				if (mit) begin
					zn.phase = pgzt_pkg::PH_MITIGATED; u_mit = 1'b1;
				end
			end
		end else if (z.phase == pgzt_pkg::PH_INVERTED) begin
			if (z.bull ? (cl > z.top) : (cl < z.bottom)) begin
				zn.phase = pgzt_pkg::PH_DEAD; u_died = 1'b1;
			end
		end
	end

	// limit clamp
	logic [NW-1:0] limit_c;
	always_comb begin
		if (limit_q == 7'd0) begin
			limit_c = NW'(1);
		end else if (32'(limit_q) > MAX_ZONES) begin
			limit_c = NW'(MAX_ZONES);
		end else begin
			limit_c = NW'(limit_q);
		end
	end

	logic walk_issue;
	logic do_append;
	logic out_load;
	pgzt_pkg::zone_t new_z;

	// post the result once the output register is free or being handed over
	assign out_load = (state_q == pgzt_pkg::ST_OUT) && (!out_vld_q || !out_stall);

	always_comb begin
		state_d = state_q;
		walk_issue = 1'b0;
		do_append = 1'b0;
		case (state_q)
			pgzt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pgzt_pkg::ST_WALK;
				end
			end
			pgzt_pkg::ST_WALK: begin
				// issue reads while zones remain; advance once the last read returns
				walk_issue = (walk_q < count_q);
				if (!walk_issue && !rd_vld_s1) begin
					state_d = pgzt_pkg::ST_DETECT;
				end
			end
			pgzt_pkg::ST_DETECT: begin
				if (det_step_q == 2'd2) begin
					do_append = acc_q && gap_ok_q;
					state_d = pgzt_pkg::ST_TRIM;
				end
			end
			pgzt_pkg::ST_TRIM: begin
				if (count_q <= limit_c) begin
					state_d = pgzt_pkg::ST_OUT;
				end
			end
			pgzt_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = pgzt_pkg::ST_IDLE;
				end
			end
			default: state_d = pgzt_pkg::ST_IDLE;
		endcase
	end

	assign ram_raddr = wrap({1'b0, head_q} + (AW+1)'(walk_q));
	assign new_z = '{top: top_q, bottom: bot_q, bull: bull_q,
		phase: pgzt_pkg::PH_ACTIVE, wick_full: 1'b0, wick_half: 1'b0};

	logic [AW-1:0] app_head;
	logic [NW-1:0] app_cnt;
	always_comb begin
		if (count_q >= NW'(MAX_ZONES)) begin
			app_head = wrap({1'b0, head_q} + (AW+1)'(1));
			app_cnt  = count_q - NW'(1);
		end else begin
			app_head = head_q;
			app_cnt  = count_q;
		end
		if (do_append) begin
			ram_we    = 1'b1;
			ram_waddr = wrap({1'b0, app_head} + (AW+1)'(app_cnt));
			ram_wdata = new_z;
		end else begin
			ram_we    = rd_vld_s1;
			ram_waddr = rd_addr_s1;
			ram_wdata = zn;
		end
	end

	// gap detection values
	logic nb, ns;
	logic [PW-1:0] g_top, g_bot, body, rng;
	assign nb = lo > hh1_q;
	assign ns = hi < lh1_q;
	assign g_top = nb ? lo : lh1_q;
	assign g_bot = nb ? hh1_q : hi;
	assign body = (mc_q > mo_q) ? (mc_q - mo_q) : (mo_q - mc_q);
	assign rng = hh0_q - lh0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pgzt_pkg::ST_IDLE;
			seen_q    <= 2'd0;
			head_q    <= '0;
			count_q   <= '0;
			walk_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			det_step_q <= 2'd0;
			hh0_q <= '0; hh1_q <= '0; lh0_q <= '0; lh1_q <= '0;
			mo_q <= '0; mc_q <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= walk_issue;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				pgzt_pkg::ST_IDLE: begin
					walk_q <= '0;
					det_step_q <= 2'd0;
				end
				pgzt_pkg::ST_WALK: begin
					if (walk_issue) begin
						walk_q <= walk_q + NW'(1);
					end
				end
				pgzt_pkg::ST_DETECT: begin
					det_step_q <= det_step_q + 2'd1;
					if (do_append) begin
						head_q  <= app_head;
						count_q <= app_cnt + NW'(1);
					end
				end
				pgzt_pkg::ST_TRIM: begin
					if (count_q > limit_c) begin
						head_q  <= wrap({1'b0, head_q} + (AW+1)'(1));
						count_q <= count_q - NW'(1);
					end
				end
				pgzt_pkg::ST_OUT: begin
					// advance the bar history only when the result is posted
					if (out_load) begin
						hh1_q <= hh0_q; lh1_q <= lh0_q;
						hh0_q <= hi; lh0_q <= lo;
						mo_q <= op; mc_q <= cl;
						if (seen_q < 2'd2) begin
							seen_q <= seen_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload and counters
	always_ff @(posedge clk) begin
		rd_addr_s1 <= ram_raddr;
		if (state_q == pgzt_pkg::ST_IDLE) begin
			bar_q <= in_data;
			n_mit_q <= '0; n_inv_q <= '0; n_died_q <= '0;
			n_full_q <= '0; n_half_q <= '0;
			evict_q <= 1'b0;
		end
		if (rd_vld_s1) begin
			n_mit_q  <= n_mit_q  + CW'(u_mit);
			n_inv_q  <= n_inv_q  + CW'(u_inv);
			n_died_q <= n_died_q + CW'(u_died);
			n_full_q <= n_full_q + CW'(u_full);
			n_half_q <= n_half_q + CW'(u_half);
		end
		if (state_q == pgzt_pkg::ST_DETECT) begin
			case (det_step_q)
				2'd0: begin
					acc_q  <= (seen_q == 2'd2) && (nb || ns);
					bull_q <= nb;
					top_q  <= g_top;
					bot_q  <= g_bot;
					gap_ok_q <= (g_top - g_bot) >= PW'(min_gap_q);
					prod_a_q <= {7'd0, body} * {{PW{1'b0}}, 7'd100};
					prod_b_q <= {7'd0, rng} * {{PW{1'b0}}, min_body_q};
				end
				2'd1: begin
					if (min_body_q != 7'd0) begin
						if (hh0_q <= lh0_q || prod_a_q < prod_b_q) begin
							gap_ok_q <= 1'b0;
						end
					end
				end
				default: begin
					if (do_append && count_q >= NW'(MAX_ZONES)) begin
						evict_q <= 1'b1;
					end
				end
			endcase
		end
		if (state_q == pgzt_pkg::ST_TRIM && count_q > limit_c) begin
			evict_q <= 1'b1;
		end
		if (out_load) begin
			res_q.new_zone        <= acc_q && gap_ok_q;
			res_q.new_bullish     <= acc_q && gap_ok_q && bull_q;
			res_q.new_top         <= (acc_q && gap_ok_q) ? top_q : '0;
			res_q.new_bottom      <= (acc_q && gap_ok_q) ? bot_q : '0;
			res_q.mitigated_count <= n_mit_q;
			res_q.inverted_count  <= n_inv_q;
			res_q.died_count      <= n_died_q;
			res_q.wick_full_count <= n_full_q;
			res_q.wick_half_count <= n_half_q;
			res_q.zones_held      <= CW'(count_q);
			res_q.zone_evicted    <= evict_q;
		end
	end

	// take a bar word whenever idle; the output register parts the two sides
	assign in_stall  = (state_q != pgzt_pkg::ST_IDLE);
	assign out_valid = out_vld_q;
	assign out_data  = res_q;

	`PGZ_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= NW'(MAX_ZONES),
		"ring count above depth")
	`PGZ_ASSERT_IMP(a_walk_bound, clk, arst_n, state_q == pgzt_pkg::ST_WALK,
		walk_q <= count_q, "walk ran past ring count")
	`PGZ_ASSERT_NEXT(a_out_after, clk, arst_n, out_load, out_vld_q,
		"result not posted after bar")
	`PGZ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_vld_q && out_stall,
		out_vld_q && $stable(res_q), "stalled result word changed")
	`PGZ_ASSERT_IMP(a_no_wr_clash, clk, arst_n, do_append, !rd_vld_s1,
		"append collides with walk write-back")

endmodule
